// File: design/fr_pkg.sv
`timescale 1ns / 1ps

package fr_pkg;

    // packet layout
    localparam int PACKET_BYTES = 255;
    localparam int HEADER_BYTES = 8;
    localparam int DATA_BYTES   = PACKET_BYTES - HEADER_BYTES;

    // header byte positions
    localparam logic [7:0] POS_FLAGS   = 8'd0;
    localparam logic [7:0] POS_SOURCE  = 8'd1;
    localparam logic [7:0] POS_SEQ_HI  = 8'd2;
    localparam logic [7:0] POS_SEQ_LO  = 8'd3;
    localparam logic [7:0] POS_OFF_HI  = 8'd6;
    localparam logic [7:0] POS_OFF_LO  = 8'd7;

    localparam logic [15:0] BUF_LEN_RESET = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // result queue depth
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        message_done;
        logic [15:0] message_length;
        logic [7:0]  message_source;
    } fr_result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } fr_item_t;

endpackage

// File: design/fr_front.sv
`timescale 1ns / 1ps

module fr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  fr_pkg::fr_item_t  item,
    output logic              push,
    output fr_pkg::fr_result_t result
);
    import fr_pkg::*;

    logic [15:0] buf_len_reg;
    logic [7:0]  pos_reg,     pos_next;
    logic        more_reg,    more_next;
    logic [7:0]  psrc_reg,    psrc_next;
    logic [15:0] pseq_reg,    pseq_next;
    logic [15:0] foff_reg,    foff_next;
    logic [15:0] mseq_reg,    mseq_next;
    logic [7:0]  morig_reg,   morig_next;
    logic [15:0] rcount_reg,  rcount_next;
    logic        drop_reg,    drop_next;

    logic [7:0]  idx;
    logic [16:0] addr_full;
    logic [15:0] room;
    logic [7:0]  dlen;
    logic [15:0] add_amt;
    logic [16:0] sum;
    logic        wv;
    logic        done;

    always_comb begin
        pos_next    = pos_reg;
        more_next   = more_reg;
        psrc_next   = psrc_reg;
        pseq_next   = pseq_reg;
        foff_next   = foff_reg;
        mseq_next   = mseq_reg;
        morig_next  = morig_reg;
        rcount_next = rcount_reg;
        drop_next   = drop_reg;
        wv          = 1'b0;
        done        = 1'b0;
        idx         = pos_reg - 8'(HEADER_BYTES);
        addr_full   = {1'b0, foff_reg} + 17'(idx);
        room        = '0;
        dlen        = '0;
        add_amt     = '0;
        sum         = '0;
        result      = '0;

        // header capture and data byte write
        if (pos_reg < 8'(PACKET_BYTES)) begin
            if (pos_reg == POS_FLAGS) begin
                more_next = item.rx_byte[0];
            end else if (pos_reg == POS_SOURCE) begin
                psrc_next = item.rx_byte;
            end else if (pos_reg == POS_SEQ_HI) begin
                pseq_next[15:8] = item.rx_byte;
            end else if (pos_reg == POS_SEQ_LO) begin
                pseq_next[7:0] = item.rx_byte;
            end else if (pos_reg == POS_OFF_HI) begin
                foff_next[15:8] = item.rx_byte;
            end else if (pos_reg == POS_OFF_LO) begin
                foff_next[7:0] = item.rx_byte;
                if (rcount_reg == '0) begin
                    mseq_next  = pseq_reg;
                    morig_next = psrc_reg;
                    drop_next  = 1'b0;
                end else begin
                    drop_next = (mseq_reg != pseq_reg) || (morig_reg != psrc_reg);
                end
            end else if (pos_reg >= 8'(HEADER_BYTES) && !drop_reg) begin
                if (addr_full < {1'b0, buf_len_reg}) begin
                    wv = 1'b1;
                end
            end
            pos_next = pos_reg + 8'd1;
        end

        result.write_valid    = wv;
        result.write_addr     = wv ? addr_full[15:0] : 16'd0;
        result.write_data     = wv ? item.rx_byte : 8'd0;
        result.message_source = morig_next;

        // packet end: account received bytes, maybe close the message
        if (item.end_of_packet) begin
            if (pos_next >= 8'(HEADER_BYTES) && !drop_next) begin
                room = (buf_len_reg > foff_next) ? (buf_len_reg - foff_next) : 16'd0;
                dlen = pos_next - 8'(HEADER_BYTES);
                if (more_next) begin
                    if ((17'(foff_next) + 17'(DATA_BYTES)) > {1'b0, buf_len_reg}) begin
                        add_amt = room;
                        done    = 1'b1;
                    end else begin
                        add_amt = 16'(DATA_BYTES);
                    end
                end else begin
                    if ((17'(foff_next) + 17'(dlen)) > {1'b0, buf_len_reg}) begin
                        add_amt = room;
                    end else begin
                        add_amt = 16'(dlen);
                    end
                    done = 1'b1;
                end
                sum         = {1'b0, rcount_reg} + {1'b0, add_amt};
                rcount_next = sum[16] ? COUNT_MAX : sum[15:0];
                if (done) begin
                    result.message_length = rcount_next;
                    rcount_next = '0;
                    mseq_next   = '0;
                    morig_next  = '0;
                end
            end
            pos_next  = '0;
            drop_next = 1'b0;
        end

        result.message_done = done;
    end

    assign push = item.valid && (wv || done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_len_reg <= BUF_LEN_RESET;
            pos_reg     <= '0;
            more_reg    <= 1'b0;
            psrc_reg    <= '0;
            pseq_reg    <= '0;
            foff_reg    <= '0;
            mseq_reg    <= '0;
            morig_reg   <= '0;
            rcount_reg  <= '0;
            drop_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                buf_len_reg <= cfg_wr_data;
            end
            if (item.valid) begin
                pos_reg    <= pos_next;
                more_reg   <= more_next;
                psrc_reg   <= psrc_next;
                pseq_reg   <= pseq_next;
                foff_reg   <= foff_next;
                mseq_reg   <= mseq_next;
                morig_reg  <= morig_next;
                rcount_reg <= rcount_next;
                drop_reg   <= drop_next;
            end
        end
    end

endmodule

// File: design/fr_queue.sv
`timescale 1ns / 1ps

module fr_queue #(
    parameter int DEPTH = fr_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  fr_pkg::fr_result_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output fr_pkg::fr_result_t out_data
);
    import fr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fr_result_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/fragment_reassembler_core.sv
`timescale 1ns / 1ps

// Fragment reassembler: takes one received link-packet byte per transaction on
// the s_ channel (header first, s_end_of_packet on the last byte) and rebuilds
// one message into an external buffer. Each data byte that lands below buf_len
// comes out on the m_ channel as a buffer write; when the message completes or
// runs past the buffer, a transaction carries message_done with the received
// length and source. Bytes that cause neither produce no m_ transaction. One
// byte is accepted every cycle that s_ready is high: the front end does the
// header capture, address compare and length accounting in that cycle, and a
// small result queue in front of the m_ port lets the output stall on its own.
// s_ready drops only when that queue is full. buf_len resets to 65535 and may
// be written through cfg_wr_en / cfg_wr_data while no transaction is in flight.

module fragment_reassembler_core #(
    parameter int QUEUE_DEPTH = fr_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: buffer length
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    // received bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_packet,

    // buffer writes and message completion
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_valid,
    output logic [15:0] m_write_addr,
    output logic [7:0]  m_write_data,
    output logic        m_message_done,
    output logic [15:0] m_message_length,
    output logic [7:0]  m_message_source
);
    import fr_pkg::*;

    fr_item_t   item;
    fr_result_t front_result;
    fr_result_t queue_head;
    logic       front_push;
    logic       queue_full;

    // front end sees a byte only in the cycle its transaction is accepted
    assign s_ready            = !queue_full;
    assign item.valid         = s_valid && s_ready;
    assign item.rx_byte       = s_rx_byte;
    assign item.end_of_packet = s_end_of_packet;

    fr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .push        (front_push),
        .result      (front_result)
    );

    // result queue decouples the byte intake from the write/report side
    fr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_data (front_result),
        .full      (queue_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (queue_head)
    );

    assign m_write_valid    = queue_head.write_valid;
    assign m_write_addr     = queue_head.write_addr;
    assign m_write_data     = queue_head.write_data;
    assign m_message_done   = queue_head.message_done;
    assign m_message_length = queue_head.message_length;
    assign m_message_source = queue_head.message_source;

endmodule

// File: tb/fragment_reassembler_core_tb.sv
`timescale 1ns / 1ps

module fragment_reassembler_core_tb;

    import fr_pkg::*;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_BYTES    = 170;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 14;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        s_end_of_packet = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_write_valid;
    logic [15:0] m_write_addr;
    logic [7:0]  m_write_data;
    logic        m_message_done;
    logic [15:0] m_message_length;
    logic [7:0]  m_message_source;

    fragment_reassembler_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_end_of_packet  (s_end_of_packet),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_write_valid    (m_write_valid),
        .m_write_addr     (m_write_addr),
        .m_write_data     (m_write_data),
        .m_message_done   (m_message_done),
        .m_message_length (m_message_length),
        .m_message_source (m_message_source)
    );

    always #2 aclk = ~aclk;

    // bytes waiting to be sent, and buffer writes / completions still owed by the block
    fr_item_t   rx_stream[$];
    fr_result_t expected_ops[$];

    int items_queued = 0;
    int error_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int stim_phase = 0;
    logic m_hold = 1'b0;

    // shadow of the reassembly state
    logic [15:0] buf_len_cfg = BUF_LEN_RESET;
    logic [7:0]  rx_pos = '0;
    logic        frag_more = 1'b0;
    logic [7:0]  pkt_src = '0;
    logic [15:0] pkt_seq = '0;
    logic [15:0] frag_off = '0;
    logic [15:0] msg_seq = '0;
    logic [7:0]  msg_src = '0;
    logic [15:0] rx_count = '0;
    logic        drop_pkt = 1'b0;

    function automatic logic [15:0] count_add(input logic [15:0] c, input int add);
        int s;
        s = int'(c) + add;
        return (s > int'(COUNT_MAX)) ? COUNT_MAX : 16'(s);
    endfunction

    // advance the shadow state by one received byte, queue the transaction it causes
    function automatic void reassemble_byte(input logic [7:0] b, input logic eop);
        fr_result_t r;
        int addr;
        int off;
        int lim;
        int room;
        int dlen;
        r = '0;
        if (rx_pos < PACKET_BYTES) begin
            case (rx_pos)
                POS_FLAGS: frag_more = b[0];
                POS_SOURCE: pkt_src = b;
                POS_SEQ_HI: pkt_seq[15:8] = b;
                POS_SEQ_LO: pkt_seq[7:0] = b;
                POS_OFF_HI: frag_off[15:8] = b;
                POS_OFF_LO: begin
                    frag_off[7:0] = b;
                    // an empty message adopts this packet, otherwise it must match
                    if (rx_count == 0) begin
                        msg_seq = pkt_seq;
                        msg_src = pkt_src;
                        drop_pkt = 1'b0;
                    end else begin
                        drop_pkt = (msg_seq != pkt_seq) || (msg_src != pkt_src);
                    end
                end
                default: begin
                    if (rx_pos >= HEADER_BYTES && !drop_pkt) begin
                        addr = int'(frag_off) + int'(rx_pos) - HEADER_BYTES;
                        if (addr < int'(buf_len_cfg)) begin
                            r.write_valid = 1'b1;
                            r.write_addr = 16'(addr);
                            r.write_data = b;
                        end
                    end
                end
            endcase
            rx_pos = rx_pos + 8'd1;
        end
        r.message_source = msg_src;

        if (eop) begin
            // packets that end inside the header leave the count alone
            if (rx_pos >= HEADER_BYTES && !drop_pkt) begin
                off = int'(frag_off);
                lim = int'(buf_len_cfg);
                room = (lim > off) ? lim - off : 0;
                if (frag_more) begin
                    if (off + DATA_BYTES > lim) begin
                        rx_count = count_add(rx_count, room);
                        r.message_done = 1'b1;
                    end else begin
                        rx_count = count_add(rx_count, DATA_BYTES);
                    end
                end else begin
                    dlen = int'(rx_pos) - HEADER_BYTES;
                    rx_count = count_add(rx_count, (off + dlen > lim) ? room : dlen);
                    r.message_done = 1'b1;
                end
                if (r.message_done) begin
                    r.message_length = rx_count;
                    rx_count = '0;
                    msg_seq = '0;
                    msg_src = '0;
                end
            end
            rx_pos = '0;
            drop_pkt = 1'b0;
        end

        if (r.write_valid || r.message_done)
            expected_ops.push_back(r);
    endfunction

    // one packet of total_len bytes; alt_fill gives 8'hFF / 8'h00 data bytes
    task automatic queue_packet(input logic more, input logic [7:0] src, input logic [15:0] seq,
                                input logic [15:0] off, input int total_len,
                                input logic alt_fill);
        logic [7:0] hdr[HEADER_BYTES];
        fr_item_t item;
        hdr[0] = {7'($urandom), more};
        hdr[1] = src;
        hdr[2] = seq[15:8];
        hdr[3] = seq[7:0];
        hdr[4] = 8'($urandom);
        hdr[5] = 8'($urandom);
        hdr[6] = off[15:8];
        hdr[7] = off[7:0];
        for (int i = 0; i < total_len; i++) begin
            item.valid = 1'b1;
            if (i < HEADER_BYTES)
                item.rx_byte = hdr[i];
            else if (alt_fill)
                item.rx_byte = (i % 2 == 0) ? 8'hFF : 8'h00;
            else
                item.rx_byte = 8'($urandom);
            item.end_of_packet = (i == total_len - 1);
            rx_stream.push_back(item);
            items_queued++;
        end
    endtask

    // data length of a fragment: mostly short, some longer up to full, a few overlong
    function automatic int pick_data_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 90)
            return $urandom_range(0, 16);
        else if (pick < 98)
            return $urandom_range(17, DATA_BYTES);
        return $urandom_range(DATA_BYTES + 1, DATA_BYTES + 15);
    endfunction

    // stray traffic: foreign source or sequence, truncated header, or garbage bytes
    task automatic queue_noise(input logic [7:0] src, input logic [15:0] seq);
        fr_item_t item;
        int len;
        case ($urandom_range(3))
            0: queue_packet(1'b0, src ^ 8'($urandom_range(1, 255)), seq, 16'($urandom),
                            HEADER_BYTES + $urandom_range(0, 12), 1'b0);
            1: queue_packet(1'b0, src, seq ^ 16'($urandom_range(1, 65535)), 16'($urandom),
                            HEADER_BYTES + $urandom_range(0, 12), 1'b0);
            2: queue_packet(1'($urandom), src, seq, 16'($urandom),
                            $urandom_range(1, HEADER_BYTES - 1), 1'b0);
            default: begin
                // even first byte keeps a garbage packet from opening a long message
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    item.valid = 1'b1;
                    item.rx_byte = (i == 0) ? {7'($urandom), 1'b0} : 8'($urandom);
                    item.end_of_packet = (i == len - 1);
                    rx_stream.push_back(item);
                    items_queued++;
                end
            end
        endcase
    endtask

    task automatic queue_message();
        logic [7:0]  src;
        logic [15:0] seq;
        logic [15:0] off;
        int nfrag;
        int pick;
        src = 8'($urandom);
        seq = 16'($urandom);
        nfrag = $urandom_range(1, 3);
        pick = $urandom_range(9);
        if (pick < 6)
            off = '0;
        else if (pick < 8)
            off = buf_len_cfg - 16'($urandom_range(0, 300));
        else
            off = 16'($urandom);
        for (int k = 0; k < nfrag; k++) begin
            if ($urandom_range(99) < 15)
                queue_noise(src, seq);
            queue_packet(k != nfrag - 1, src, seq, off, HEADER_BYTES + pick_data_len(), 1'b0);
            off = off + 16'(DATA_BYTES);
        end
    endtask

    task automatic set_buf_len(input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        buf_len_cfg = value;
    endtask

    // wait for every byte to go in and every owed transaction to come out;
    // sampled on the falling edge so the driver's updates have settled
    task automatic drain();
        @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || expected_ops.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // sender: a new byte only once the current one is taken
    always @(posedge aclk) begin
        fr_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                reassemble_byte(s_rx_byte, s_end_of_packet);
            if (!s_valid || s_ready) begin
                if (rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    item = rx_stream.pop_front();
                    s_valid <= 1'b1;
                    s_rx_byte <= item.rx_byte;
                    s_end_of_packet <= item.end_of_packet;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && !m_hold && ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic void report_mismatch(input string what, input fr_result_t want,
                                            input fr_result_t got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s: expected wv=%0b addr=%04h data=%02h done=%0b len=%0d src=%02h",
                     $realtime, what, want.write_valid, want.write_addr, want.write_data,
                     want.message_done, want.message_length, want.message_source);
            $display("    got wv=%0b addr=%04h data=%02h done=%0b len=%0d src=%02h",
                     got.write_valid, got.write_addr, got.write_data, got.message_done,
                     got.message_length, got.message_source);
        end
    endfunction

    // result side: each transaction against the oldest owed one
    always @(posedge aclk) begin
        fr_result_t got;
        fr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.write_valid = m_write_valid;
            got.write_addr = m_write_addr;
            got.write_data = m_write_data;
            got.message_done = m_message_done;
            got.message_length = m_message_length;
            got.message_source = m_message_source;
            if (expected_ops.size() == 0) begin
                report_mismatch("unexpected transaction", '0, got);
            end else begin
                want = expected_ops.pop_front();
                if (got.write_valid !== want.write_valid
                        || got.write_addr !== want.write_addr
                        || got.write_data !== want.write_data
                        || got.message_done !== want.message_done
                        || got.message_length !== want.message_length
                        || got.message_source !== want.message_source)
                    report_mismatch("mismatch", want, got);
            end
        end
    end

    // backpressure: receiver stops long enough for the block to fill and stall its input
    initial begin
        wait (stim_phase == 1);
        @(posedge aclk);
        m_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        m_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [15:0] buf_len_plan[NUM_PHASES];
        int target;
        buf_len_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd300, 16'($urandom), 16'd1000};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: truncated header, non-final fragment, foreign packet dropped
        // mid-message, then the final fragment closing the message
        queue_packet(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 3, 1'b1);
        queue_packet(1'b1, 8'hA5, 16'h1234, 16'd0, HEADER_BYTES, 1'b0);
        queue_packet(1'b0, 8'h5A, 16'h1234, 16'd0, HEADER_BYTES, 1'b0);
        queue_packet(1'b0, 8'hA5, 16'h1234, 16'(DATA_BYTES), HEADER_BYTES + 2, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
                default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
            endcase
            set_buf_len(buf_len_plan[p]);
            stim_phase = p + 1;
            target = items_queued + PHASE_BYTES;
            while (items_queued < target)
                queue_message();
            drain();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: fragment_reassembler_core.f
design/fr_pkg.sv
design/fr_front.sv
design/fr_queue.sv
design/fragment_reassembler_core.sv
tb/fragment_reassembler_core_tb.sv
